// ===== sv/h264rtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264rtp_pkg
// Shared types and constants of the H.264 RTP packetizer: channel items,
// configuration set, packet commands between front and back end.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

  // Fragment size limits and protocol constants
  localparam logic [10:0] FRAG_MIN      = 11'd16;
  localparam logic [10:0] FRAG_MAX      = 11'd1460;
  localparam logic [4:0]  FU_A_TYPE     = 5'd28;
  localparam logic [7:0]  RTP_V2_BYTE   = 8'h80;
  localparam logic [3:0]  PREFIX_SHORT  = 4'd3;
  localparam logic [3:0]  PREFIX_LONG   = 4'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SOURCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_SIZE  = 2'd3;

  // Command kinds
  localparam logic [1:0] CMD_SINGLE = 2'd0;  // RTP header + NAL header byte
  localparam logic [1:0] CMD_FRAG   = 2'd1;  // RTP header + FU ind + FU hdr + byte
  localparam logic [1:0] CMD_BYTE   = 2'd2;  // one payload byte

  // Command queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        unit_start;
    logic [15:0] unit_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        packet_end;
    logic [10:0] packet_length;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  payload_type;
    logic [31:0] sync_source;
    logic [31:0] timestamp_step;
    logic [10:0] fragment_size;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last_end;
    logic [10:0] pkt_len;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
  } cmd_t;

endpackage

// ===== sv/h264rtp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264rtp_front
// Parses the NAL unit byte stream: strips the start code, decides single or
// FU-A mode, tracks sequence and timestamp, and issues up to one command per item.
// ----------------------------------------------------------------------------
module h264rtp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  h264rtp_pkg::in_item_t in_item,
  input  h264rtp_pkg::cfg_t    cfg,
  output logic                 cmd_push,
  output h264rtp_pkg::cmd_t    cmd
);
  import h264rtp_pkg::*;

  logic        open_r,  open_nxt;
  logic [15:0] pos_r,   pos_nxt;
  logic [3:0]  plen_r,  plen_nxt;
  logic        zeros_r, zeros_nxt;
  logic [7:0]  nal_r,   nal_nxt;
  logic        frag_r,  frag_nxt;
  logic [10:0] chunk_r, chunk_nxt;
  logic [15:0] left_r,  left_nxt;
  logic [15:0] seq_r,   seq_nxt;
  logic [31:0] ts_r,    ts_nxt;
  logic [10:0] pktlen_r, pktlen_nxt;

  logic        e_open, e_frag;
  logic [15:0] e_pos, e_left;
  logic [3:0]  e_plen;
  logic [10:0] e_chunk;
  logic [10:0] fs;
  logic [7:0]  b;
  logic [15:0] len, n, hdr_left, left_v;
  logic        last, first;
  logic [10:0] clen, chunk_v, pkt_v;

  // Clamp the fragment size into its legal range
  always_comb begin
    if (cfg.fragment_size < FRAG_MIN) begin
      fs = FRAG_MIN;
    end else if (cfg.fragment_size > FRAG_MAX) begin
      fs = FRAG_MAX;
    end else begin
      fs = cfg.fragment_size;
    end
  end

  assign b   = in_item.data_byte;
  assign len = in_item.unit_length;

  // Per-byte parse step
  always_comb begin
    open_nxt   = open_r;
    pos_nxt    = pos_r;
    plen_nxt   = plen_r;
    zeros_nxt  = zeros_r;
    nal_nxt    = nal_r;
    frag_nxt   = frag_r;
    chunk_nxt  = chunk_r;
    left_nxt   = left_r;
    seq_nxt    = seq_r;
    ts_nxt     = ts_r;
    pktlen_nxt = pktlen_r;
    cmd_push   = 1'b0;
    cmd        = '0;
    e_open  = open_r;
    e_pos   = pos_r;
    e_plen  = plen_r;
    e_frag  = frag_r;
    e_chunk = chunk_r;
    e_left  = left_r;
    n        = 16'd0;
    hdr_left = 16'd0;
    left_v   = 16'd0;
    last     = 1'b0;
    first    = 1'b0;
    clen     = 11'd0;
    chunk_v  = 11'd0;
    pkt_v    = pktlen_r;

    if (in_accept) begin
      // Restart the unit on a start flag
      if (in_item.unit_start) begin
        e_open  = 1'b1;
        e_pos   = 16'd0;
        e_plen  = PREFIX_SHORT;
        e_frag  = 1'b0;
        e_chunk = 11'd0;
        e_left  = 16'd0;
      end
      open_nxt  = e_open;
      pos_nxt   = e_pos;
      plen_nxt  = e_plen;
      frag_nxt  = e_frag;
      chunk_nxt = e_chunk;
      left_nxt  = e_left;

      if (e_open) begin
        if (e_pos < 16'd3) begin
          // Buffer start code bytes
          zeros_nxt = ((e_pos == 16'd0) ? 1'b1 : zeros_r) & (b == 8'd0);
          pos_nxt   = e_pos + 16'd1;
        end else if (e_pos == 16'd3 && zeros_r && b == 8'd1) begin
          // Four-byte start code
          plen_nxt = PREFIX_LONG;
          pos_nxt  = 16'd4;
        end else if (e_pos == {12'd0, e_plen}) begin
          // NAL header byte
          nal_nxt = b;
          if (len <= {12'd0, e_plen}) begin
            open_nxt = 1'b0;
          end else begin
            n        = len - {12'd0, e_plen};
            hdr_left = n - 16'd1;
            left_nxt = hdr_left;
            ts_nxt   = ts_r + cfg.timestamp_step;
            pos_nxt  = e_pos + 16'd1;
            if (hdr_left <= {5'd0, fs}) begin
              frag_nxt     = 1'b0;
              pkt_v        = n[10:0] + 11'd12;
              pktlen_nxt   = pkt_v;
              cmd_push     = 1'b1;
              cmd.kind     = CMD_SINGLE;
              cmd.data     = b;
              cmd.last_end = (hdr_left == 16'd0);
              cmd.pkt_len  = pkt_v;
              cmd.marker   = 1'b1;
              cmd.seq      = seq_r;
              cmd.ts       = ts_nxt;
              seq_nxt      = seq_r + 16'd1;
              if (hdr_left == 16'd0) begin
                open_nxt = 1'b0;
              end
            end else begin
              frag_nxt  = 1'b1;
              chunk_nxt = 11'd0;
            end
          end
        end else if (e_left == 16'd0) begin
          // Drop bytes past the unit's end
          open_nxt = 1'b0;
        end else begin
          // Payload byte, opening a fragment where a chunk is used up
          chunk_v  = e_chunk;
          cmd.kind = CMD_BYTE;
          if (e_frag && e_chunk == 11'd0) begin
            last       = (e_left <= {5'd0, fs});
            clen       = last ? e_left[10:0] : fs;
            first      = (e_pos == {12'd0, e_plen} + 16'd1);
            pkt_v      = clen + 11'd14;
            chunk_v    = clen;
            cmd.kind   = CMD_FRAG;
            cmd.marker = last;
            cmd.seq    = seq_r;
            cmd.fu_ind = {nal_r[7:5], FU_A_TYPE};
            cmd.fu_hdr = {first, last, 1'b0, nal_r[4:0]};
            seq_nxt    = seq_r + 16'd1;
          end
          left_v = e_left - 16'd1;
          if (e_frag) begin
            chunk_v      = chunk_v - 11'd1;
            cmd.last_end = (chunk_v == 11'd0);
          end else begin
            cmd.last_end = (left_v == 16'd0);
          end
          cmd_push   = 1'b1;
          cmd.data   = b;
          cmd.pkt_len = pkt_v;
          cmd.ts     = ts_r;
          pktlen_nxt = pkt_v;
          chunk_nxt  = chunk_v;
          left_nxt   = left_v;
          pos_nxt    = e_pos + 16'd1;
          if (left_v == 16'd0) begin
            open_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      pos_r    <= 16'd0;
      plen_r   <= PREFIX_SHORT;
      zeros_r  <= 1'b0;
      nal_r    <= 8'd0;
      frag_r   <= 1'b0;
      chunk_r  <= 11'd0;
      left_r   <= 16'd0;
      seq_r    <= 16'd0;
      ts_r     <= 32'd0;
      pktlen_r <= 11'd0;
    end else begin
      open_r   <= open_nxt;
      pos_r    <= pos_nxt;
      plen_r   <= plen_nxt;
      zeros_r  <= zeros_nxt;
      nal_r    <= nal_nxt;
      frag_r   <= frag_nxt;
      chunk_r  <= chunk_nxt;
      left_r   <= left_nxt;
      seq_r    <= seq_nxt;
      ts_r     <= ts_nxt;
      pktlen_r <= pktlen_nxt;
    end
  end

endmodule

// ===== sv/h264rtp_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264rtp_cmd_fifo
// Short command queue between the parser front end and the byte emitter.
// ----------------------------------------------------------------------------
module h264rtp_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  h264rtp_pkg::cmd_t wr_cmd,
  input  logic              pop,
  output h264rtp_pkg::cmd_t head,
  output logic              full,
  output logic              empty
);
  import h264rtp_pkg::*;

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r,  count_nxt;
  logic               do_push, do_pop;

  assign full  = (count_r == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== sv/h264rtp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264rtp_back
// Expands queued commands into RTP packet bytes, one byte per cycle while a command
// waits and the output register is free, into that register, read through empty/pop.
// ----------------------------------------------------------------------------
module h264rtp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  h264rtp_pkg::cfg_t      cfg,
  input  h264rtp_pkg::cmd_t      head,
  input  logic                   head_valid,
  output logic                   head_pop,
  input  logic                   out_pop,
  output logic                   out_empty,
  output h264rtp_pkg::out_item_t out_item
);
  import h264rtp_pkg::*;

  // Byte positions inside a command
  localparam logic [3:0] IDX_PT      = 4'd1;
  localparam logic [3:0] IDX_SEQ_HI  = 4'd2;
  localparam logic [3:0] IDX_SEQ_LO  = 4'd3;
  localparam logic [3:0] IDX_TS_3    = 4'd4;
  localparam logic [3:0] IDX_TS_2    = 4'd5;
  localparam logic [3:0] IDX_TS_1    = 4'd6;
  localparam logic [3:0] IDX_TS_0    = 4'd7;
  localparam logic [3:0] IDX_SSRC_3  = 4'd8;
  localparam logic [3:0] IDX_SSRC_2  = 4'd9;
  localparam logic [3:0] IDX_SSRC_1  = 4'd10;
  localparam logic [3:0] IDX_SSRC_0  = 4'd11;
  localparam logic [3:0] IDX_AFTER   = 4'd12;  // NAL byte or FU indicator
  localparam logic [3:0] IDX_FU_HDR  = 4'd13;
  localparam logic [3:0] IDX_FU_DATA = 4'd14;

  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;
  logic        slot_free, step, is_last;
  logic [3:0]  last_idx;
  logic [7:0]  hdr_byte, byte_v;

  assign slot_free = !out_valid_r || out_pop;
  assign step      = slot_free && head_valid;

  // Last byte position of the head command
  always_comb begin
    case (head.kind)
      CMD_SINGLE: last_idx = IDX_AFTER;
      CMD_FRAG:   last_idx = IDX_FU_DATA;
      default:    last_idx = 4'd0;
    endcase
  end

  assign is_last  = (idx_r == last_idx);
  assign head_pop = step && is_last;

  // Select the header byte at the current position
  always_comb begin
    case (idx_r)
      IDX_PT:      hdr_byte = {head.marker, cfg.payload_type};
      IDX_SEQ_HI:  hdr_byte = head.seq[15:8];
      IDX_SEQ_LO:  hdr_byte = head.seq[7:0];
      IDX_TS_3:    hdr_byte = head.ts[31:24];
      IDX_TS_2:    hdr_byte = head.ts[23:16];
      IDX_TS_1:    hdr_byte = head.ts[15:8];
      IDX_TS_0:    hdr_byte = head.ts[7:0];
      IDX_SSRC_3:  hdr_byte = cfg.sync_source[31:24];
      IDX_SSRC_2:  hdr_byte = cfg.sync_source[23:16];
      IDX_SSRC_1:  hdr_byte = cfg.sync_source[15:8];
      IDX_SSRC_0:  hdr_byte = cfg.sync_source[7:0];
      IDX_AFTER:   hdr_byte = (head.kind == CMD_FRAG) ? head.fu_ind : head.data;
      IDX_FU_HDR:  hdr_byte = head.fu_hdr;
      IDX_FU_DATA: hdr_byte = head.data;
      default:     hdr_byte = RTP_V2_BYTE;
    endcase
  end

  assign byte_v = (head.kind == CMD_BYTE) ? head.data : hdr_byte;

  // Load the output register, drain it on pop
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (step) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.packet_byte   = byte_v;
      out_item_nxt.packet_end    = is_last && head.last_end;
      out_item_nxt.packet_length = head.pkt_len;
      idx_nxt                    = is_last ? 4'd0 : idx_r + 4'd1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/h264_rtp_packetizer_top.sv =====
`timescale 1ns / 1ps
// When the command queue is empty, a byte that starts a packet passes the command queue
// and then the output register before its first result shows.
// Throughput: one input byte per cycle while the queue has room; the byte emitter puts
// out one packet byte per cycle while its output is popped, so each packet start expands
// to 13 (single) or 15 (fragment) bytes, buffered by a 4-entry queue before the emitter.
// Reset (rst_n low, synchronous): queue and output empty, unit closed, sequence and
// timestamp zero, registers back to payload type 96, SSRC 10, step 3600, size 1400.
// ----------------------------------------------------------------------------
// h264_rtp_packetizer_top
// H.264 RTP packetizer: start code stripping, single NAL and FU-A packets.
// ----------------------------------------------------------------------------
module h264_rtp_packetizer_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  input  h264rtp_pkg::in_item_t                  in_item,
  output logic                                   in_full,
  input  logic                                   out_pop,
  output logic                                   out_empty,
  output h264rtp_pkg::out_item_t                 out_item,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [h264rtp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                            cfg_data
);
  import h264rtp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd, head;
  logic cmd_push, fifo_full, fifo_empty, head_pop, in_accept;

  assign cfg_ready = 1'b1;
  assign in_full   = fifo_full;
  assign in_accept = in_push && !fifo_full;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_PAYLOAD_TYPE:   cfg_nxt.payload_type   = cfg_data[6:0];
        CFG_SYNC_SOURCE:    cfg_nxt.sync_source    = cfg_data;
        CFG_TIMESTAMP_STEP: cfg_nxt.timestamp_step = cfg_data;
        CFG_FRAGMENT_SIZE:  cfg_nxt.fragment_size  = cfg_data[10:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_type   <= 7'd96;
      cfg_r.sync_source    <= 32'd10;
      cfg_r.timestamp_step <= 32'd3600;
      cfg_r.fragment_size  <= 11'd1400;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  h264rtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  h264rtp_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd),
    .pop    (head_pop),
    .head   (head),
    .full   (fifo_full),
    .empty  (fifo_empty)
  );

  h264rtp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (!fifo_empty),
    .head_pop   (head_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_item   (out_item)
  );

endmodule

// ===== sv/h264rtp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264rtp_checker
// Port-level checks of the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
module h264rtp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_push,
  input h264rtp_pkg::in_item_t             in_item,
  input logic                              in_full,
  input logic                              out_pop,
  input logic                              out_empty,
  input h264rtp_pkg::out_item_t            out_item,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [h264rtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                       cfg_data
);
  import h264rtp_pkg::*;

  // Hold a waiting item until it is popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed before pop");

  // Come out of reset with nothing queued and room for input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("not empty after reset");

  // Every packet carries at least a header and one byte
  a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.packet_length >= 11'd13))
    else $error("packet length below header size");

  // Take configuration writes at any time
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind h264_rtp_packetizer_top h264rtp_checker u_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H.264 RTP packetizer. NAL units go in a byte at
// a time, and every packet byte that comes out is compared with a local
// packet builder that tracks start codes, sequence, timestamp and FU-A
// fragmentation. It runs a directed pass, then random units under four
// idling modes and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import h264rtp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int MAX_REPORTS    = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  in_item_t             in_item = '0;
  logic                 in_full;
  logic                 out_pop = 1'b0;
  logic                 out_empty;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Idling controls, in percent
  int send_gap_pct  = 0;
  int pop_stall_pct = 0;

  // Run statistics and failures
  int bytes_taken   = 0;
  int bytes_ignored = 0;
  int bytes_checked = 0;
  int packets_seen  = 0;
  int reg_writes    = 0;
  int error_count   = 0;
  int idle_cycles   = 0;

  // Packet bytes still owed by the block, oldest first
  out_item_t pending_bytes[$];

  // Register copies and packet builder state
  cfg_t        reg_shadow   = '{payload_type: 7'd96, sync_source: 32'd10,
                                timestamp_step: 32'd3600, fragment_size: 11'd1400};
  logic [7:0]  start_code [3] = '{8'h00, 8'h00, 8'h00};
  logic [15:0] byte_pos     = '0;
  logic [3:0]  prefix_len   = PREFIX_SHORT;
  logic [7:0]  nal_hdr      = '0;
  logic        fragmenting  = 1'b0;
  logic [10:0] chunk_left   = '0;
  logic [15:0] payload_left = '0;
  logic [15:0] rtp_seq      = '0;
  logic [31:0] rtp_ts       = '0;
  logic        unit_open    = 1'b0;
  logic [10:0] pkt_len      = '0;

  h264_rtp_packetizer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock and reset
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Packet builder
  // ---------------------------------------------------------------------------

  // Clamp the fragment size into its legal range
  function automatic logic [10:0] frag_limit();
    if (reg_shadow.fragment_size < FRAG_MIN) return FRAG_MIN;
    if (reg_shadow.fragment_size > FRAG_MAX) return FRAG_MAX;
    return reg_shadow.fragment_size;
  endfunction

  function automatic void owe_byte(input logic [7:0] b, input logic eop);
    out_item_t e;
    e.packet_byte   = b;
    e.packet_end    = eop;
    e.packet_length = pkt_len;
    pending_bytes.push_back(e);
  endfunction

  // Queue the 12 RTP header bytes and advance the sequence number
  function automatic void owe_rtp_header(input logic marker);
    owe_byte(RTP_V2_BYTE, 1'b0);
    owe_byte({marker, reg_shadow.payload_type}, 1'b0);
    owe_byte(rtp_seq[15:8], 1'b0);
    owe_byte(rtp_seq[7:0], 1'b0);
    owe_byte(rtp_ts[31:24], 1'b0);
    owe_byte(rtp_ts[23:16], 1'b0);
    owe_byte(rtp_ts[15:8], 1'b0);
    owe_byte(rtp_ts[7:0], 1'b0);
    owe_byte(reg_shadow.sync_source[31:24], 1'b0);
    owe_byte(reg_shadow.sync_source[23:16], 1'b0);
    owe_byte(reg_shadow.sync_source[15:8], 1'b0);
    owe_byte(reg_shadow.sync_source[7:0], 1'b0);
    rtp_seq = rtp_seq + 16'd1;
  endfunction

  // Advance on one accepted byte; return 0 when the byte is dropped unseen
  function automatic bit packetize_byte(input in_item_t it);
    logic [10:0] fs;
    logic [15:0] pos;
    logic [15:0] n;
    logic [10:0] clen;
    logic        is_first;
    logic        is_last;
    fs = frag_limit();
    if (it.unit_start) begin
      unit_open    = 1'b1;
      byte_pos     = '0;
      prefix_len   = PREFIX_SHORT;
      fragmenting  = 1'b0;
      chunk_left   = '0;
      payload_left = '0;
    end
    if (!unit_open) return 1'b0;
    pos = byte_pos;

    // Buffer the first three start code bytes
    if (pos < 16'd3) begin
      start_code[pos[1:0]] = it.data_byte;
      byte_pos = pos + 16'd1;
      return 1'b1;
    end
    if (pos == 16'd3) begin
      if (start_code[0] == 8'h00 && start_code[1] == 8'h00 && start_code[2] == 8'h00 &&
          it.data_byte == 8'h01) begin
        prefix_len = PREFIX_LONG;
        byte_pos   = 16'd4;
        return 1'b1;
      end
      prefix_len = PREFIX_SHORT;
    end

    // NAL header byte: choose single packet or fragmentation
    if (pos == 16'(prefix_len)) begin
      nal_hdr = it.data_byte;
      if (it.unit_length <= 16'(prefix_len)) begin
        unit_open = 1'b0;
        return 1'b1;
      end
      n            = it.unit_length - 16'(prefix_len);
      payload_left = n - 16'd1;
      rtp_ts       = rtp_ts + reg_shadow.timestamp_step;
      byte_pos     = pos + 16'd1;
      if (payload_left <= 16'(fs)) begin
        fragmenting = 1'b0;
        pkt_len     = n[10:0] + 11'd12;
        owe_rtp_header(1'b1);
        owe_byte(it.data_byte, payload_left == 16'd0);
        if (payload_left == 16'd0) unit_open = 1'b0;
      end else begin
        fragmenting = 1'b1;
        chunk_left  = '0;
      end
      return 1'b1;
    end

    // Payload byte; bytes past the end close the unit
    if (payload_left == 16'd0) begin
      unit_open = 1'b0;
      return 1'b1;
    end
    if (fragmenting && chunk_left == 11'd0) begin
      is_last  = (payload_left <= 16'(fs));
      clen     = is_last ? payload_left[10:0] : fs;
      is_first = (pos == 16'(prefix_len) + 16'd1);
      pkt_len  = clen + 11'd14;
      owe_rtp_header(is_last);
      owe_byte({nal_hdr[7:5], FU_A_TYPE}, 1'b0);
      owe_byte({is_first, is_last, 1'b0, nal_hdr[4:0]}, 1'b0);
      chunk_left = clen;
    end
    payload_left = payload_left - 16'd1;
    if (fragmenting) begin
      chunk_left = chunk_left - 11'd1;
      owe_byte(it.data_byte, chunk_left == 11'd0);
    end else begin
      owe_byte(it.data_byte, payload_left == 16'd0);
    end
    byte_pos = pos + 16'd1;
    if (payload_left == 16'd0) unit_open = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_bytes.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected packet byte %02h end %0b len %0d",
                   out_item.packet_byte, out_item.packet_end, out_item.packet_length);
      end else begin
        want = pending_bytes.pop_front();
        if (out_item.packet_byte !== want.packet_byte ||
            out_item.packet_end !== want.packet_end ||
            out_item.packet_length !== want.packet_length) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch at byte %0d: expected %02h end %0b len %0d, got %02h end %0b len %0d",
                     bytes_checked, want.packet_byte, want.packet_end, want.packet_length,
                     out_item.packet_byte, out_item.packet_end, out_item.packet_length);
        end
      end
      bytes_checked++;
      if (out_item.packet_end === 1'b1) packets_seen++;
    end
  end

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d bytes owed",
               idle_cycles, pending_bytes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one item, idling first at random, and track it once accepted
  task automatic send_item(input logic [7:0] data, input logic start, input logic [15:0] len);
    in_item_t it;
    it.data_byte   = data;
    it.unit_start  = start;
    it.unit_length = len;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (packetize_byte(it)) bytes_taken++;
    else bytes_ignored++;
  endtask

  // Hold the input and wait until every owed byte has come out
  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PAYLOAD_TYPE:   reg_shadow.payload_type   = val[6:0];
      CFG_SYNC_SOURCE:    reg_shadow.sync_source    = val;
      CFG_TIMESTAMP_STEP: reg_shadow.timestamp_step = val;
      CFG_FRAGMENT_SIZE:  reg_shadow.fragment_size  = val[10:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Write all four registers with the block idle
  task automatic load_config(input logic [31:0] pt, input logic [31:0] ssrc,
                             input logic [31:0] step, input logic [31:0] fsize);
    wait_drained();
    write_reg(CFG_PAYLOAD_TYPE, pt);
    write_reg(CFG_SYNC_SOURCE, ssrc);
    write_reg(CFG_TIMESTAMP_STEP, step);
    write_reg(CFG_FRAGMENT_SIZE, fsize);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send the first nbytes of a unit: start code, NAL header, random payload
  task automatic send_unit(input logic long_code, input logic [7:0] nal,
                           input logic [15:0] len, input int nbytes);
    int code_len;
    code_len = long_code ? 4 : 3;
    for (int i = 0; i < nbytes; i++) begin
      if (i < code_len)
        send_item((i == code_len - 1) ? 8'h01 : 8'h00, i == 0, len);
      else if (i == code_len)
        send_item(nal, 1'b0, len);
      else
        send_item(8'($urandom_range(0, 255)), 1'b0, len);
    end
  endtask

  // Random units, mostly well formed, until budget bytes have been taken
  task automatic stream_units(input int budget);
    int          goal;
    int          k;
    int          kind;
    int          code_len;
    logic        long_code;
    logic [15:0] len;
    goal = bytes_taken + budget;
    while (bytes_taken < goal) begin
      // drain now and then so the sender pauses with nothing in flight
      if ($urandom_range(0, 9) == 0) wait_drained();
      long_code = 1'($urandom_range(0, 1));
      code_len  = long_code ? 4 : 3;
      kind      = $urandom_range(0, 99);
      if (kind < 65) begin
        // complete unit, sometimes sized right at the single/fragment edge
        if ($urandom_range(0, 3) == 0 && frag_limit() <= 11'd64)
          k = int'(frag_limit()) - 1 + $urandom_range(0, 2);
        else
          k = $urandom_range(0, 60);
        len = 16'(code_len + 1 + k);
        send_unit(long_code, 8'($urandom_range(0, 255)), len, int'(len));
        repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0, len);
      end else if (kind < 75) begin
        // length no longer than the start code
        len = 16'($urandom_range(0, code_len));
        send_unit(long_code, 8'($urandom_range(0, 255)), len, code_len + 1);
      end else if (kind < 90) begin
        // any length, cut off by the next unit start
        len = 16'($urandom_range(0, 65535));
        send_unit(long_code, 8'($urandom_range(0, 255)), len,
                  code_len + 1 + $urandom_range(0, 24));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)));
      end
    end
    // close with a complete unit so none stays open across a register write
    len = 16'(4 + $urandom_range(0, 40));
    send_unit(1'b0, 8'($urandom_range(0, 255)), len, int'(len));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    send_gap_pct  = 0;
    pop_stall_pct = 0;
    // all registers at their low end; size 0 acts as 16
    load_config(32'd0, 32'd0, 32'd0, 32'd0);
    // drop a byte that arrives with no unit open
    send_item(8'hFF, 1'b0, 16'hFFFF);
    // four-byte start code, unit holding only its NAL header
    send_unit(1'b1, 8'h00, 16'd5, 5);
    // length covers only the start code: no packet
    send_unit(1'b0, 8'h65, 16'd3, 4);
    // longest length, abandoned after the first fragment has begun
    send_unit(1'b0, 8'h41, 16'hFFFF, 6);
    // F bit set; 17 payload bytes split into 16 and a one-byte remainder
    send_unit(1'b0, 8'hFF, 16'd21, 21);
  endtask

  task automatic test_back_to_back();
    send_gap_pct  = 0;
    pop_stall_pct = 0;
    load_config(32'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16);
    stream_units(20);
  endtask

  task automatic test_sender_gaps();
    send_gap_pct  = 82;
    pop_stall_pct = 0;
    // size beyond the top acts as 1460
    load_config($urandom_range(0, 127), $urandom, $urandom, 32'd2047);
    stream_units(20);
  endtask

  task automatic test_receiver_stalls();
    send_gap_pct  = 0;
    pop_stall_pct = 82;
    load_config($urandom_range(0, 127), $urandom, 32'd3600, 32'd1460);
    stream_units(20);
  endtask

  task automatic test_both_sides_idle();
    send_gap_pct  = 31;
    pop_stall_pct = 31;
    load_config($urandom_range(0, 127), $urandom, $urandom, $urandom_range(17, 48));
    stream_units(20);
  endtask

  initial begin
    @(posedge rst_n);
    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    wait_drained();
    if (pending_bytes.size() != 0) error_count++;
    $display("Sent %0d unit bytes (%0d more dropped as idle), checked %0d packet bytes in %0d packets.",
             bytes_taken, bytes_ignored, bytes_checked, packets_seen);
    $display("Made %0d register writes over five settings; %0d failures.", reg_writes, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/h264rtp_pkg.sv
sv/h264rtp_front.sv
sv/h264rtp_cmd_fifo.sv
sv/h264rtp_back.sv
sv/h264_rtp_packetizer_top.sv
sv/h264rtp_checker.sv
sim/tb_top.sv
